>>> rtl/fbsc_pkg.sv
// fbsc_pkg: constants and types shared by the byte-stuffing codec
// no dependencies
package fbsc_pkg;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;

    localparam logic [7:0] BYTE_FLAG  = 8'h7E;
    localparam logic [7:0] BYTE_END   = 8'h7D;
    localparam logic [7:0] BYTE_ESC   = 8'h7C;
    localparam logic [7:0] CODE_FLAG  = 8'h5E;
    localparam logic [7:0] CODE_END   = 8'h5D;
    localparam logic [7:0] CODE_ESC   = 8'h5C;
    localparam logic [7:0] BYTE_NONE  = 8'h00;

    // special byte and its escape code differ only in this bit
    localparam logic [7:0] CODE_XOR   = 8'h20;

    typedef struct packed {
        logic [7:0] byte0;
        logic       valid0;
        logic       eof0;
        logic       two;
        logic [7:0] byte1;
        logic       valid1;
        logic       eof1;
    } cmd_t;

    function automatic logic is_special(input logic [7:0] b);
        return (b == BYTE_FLAG) || (b == BYTE_END) || (b == BYTE_ESC);
    endfunction

    function automatic logic is_code(input logic [7:0] b);
        return (b == CODE_FLAG) || (b == CODE_END) || (b == CODE_ESC);
    endfunction

endpackage

>>> rtl/fbsc_channels.sv
// fbsc channel interfaces: input items, result items and configuration writes
// no dependencies
interface fbsc_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_start,
                    output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_start,
                    input frame_last, output ready);
endinterface

interface fbsc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_frame;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_frame, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_frame, input last, output ready);
endinterface

interface fbsc_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

>>> rtl/fbsc_front.sv
// fbsc_front: accepts input bytes, holds direction and escape state,
// classifies each byte into a command of up to two results; uses fbsc_pkg
module fbsc_front
(
    input  logic               clk,
    input  logic               rst_n,
    fbsc_cfg_if.sink           cfg,
    fbsc_item_if.sink          item,
    input  logic               q_ready,
    output logic               q_push,
    output fbsc_pkg::cmd_t     q_cmd
);

    logic           direction_reg;
    logic           direction_next;
    logic           escape_pending_reg;
    logic           escape_pending_next;
    logic           produce;
    logic           escape_after;
    logic           accept;
    fbsc_pkg::cmd_t cmd;

    assign cfg.ready  = 1'b1;
    assign item.ready = q_ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        cmd          = '0;
        produce      = 1'b1;
        escape_after = escape_pending_reg;
        if (direction_reg == fbsc_pkg::DIR_ENCODE)
        begin
            cmd.byte0  = item.data_byte;
            cmd.valid0 = 1'b1;
            cmd.eof0   = item.frame_last;
            if (!item.frame_start && fbsc_pkg::is_special(item.data_byte))
            begin
                cmd.byte0  = fbsc_pkg::BYTE_ESC;
                cmd.eof0   = 1'b0;
                cmd.two    = 1'b1;
                cmd.byte1  = item.data_byte ^ fbsc_pkg::CODE_XOR;
                cmd.valid1 = 1'b1;
                cmd.eof1   = item.frame_last;
            end
        end
        else if (escape_pending_reg && fbsc_pkg::is_code(item.data_byte))
        begin
            cmd.byte0    = item.data_byte ^ fbsc_pkg::CODE_XOR;
            cmd.valid0   = 1'b1;
            escape_after = 1'b0;
        end
        else if (escape_pending_reg)
        begin
            // broken escape: give the escape byte, then treat the byte plainly
            cmd.byte0    = fbsc_pkg::BYTE_ESC;
            cmd.valid0   = 1'b1;
            escape_after = 1'b0;
            priority if (item.data_byte == fbsc_pkg::BYTE_END)
            begin
                cmd.two  = 1'b1;
                cmd.eof1 = 1'b1;
            end
            else if (item.data_byte == fbsc_pkg::BYTE_ESC)
            begin
                escape_after = 1'b1;
            end
            else
            begin
                cmd.two    = 1'b1;
                cmd.byte1  = item.data_byte;
                cmd.valid1 = 1'b1;
            end
        end
        else
        begin
            priority if (item.data_byte == fbsc_pkg::BYTE_END)
            begin
                cmd.eof0     = 1'b1;
                escape_after = 1'b0;
            end
            else if (item.data_byte == fbsc_pkg::BYTE_ESC)
            begin
                produce      = 1'b0;
                escape_after = 1'b1;
            end
            else
            begin
                cmd.byte0  = item.data_byte;
                cmd.valid0 = 1'b1;
            end
        end
    end

    assign q_push = accept && produce;
    assign q_cmd  = cmd;

    always_comb
    begin
        direction_next      = direction_reg;
        escape_pending_next = escape_pending_reg;
        if (cfg.valid && cfg.ready)
        begin
            direction_next      = cfg.direction;
            escape_pending_next = 1'b0;
        end
        else if (accept && direction_reg == fbsc_pkg::DIR_DECODE)
        begin
            escape_pending_next = escape_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg      <= fbsc_pkg::DIR_ENCODE;
            escape_pending_reg <= 1'b0;
        end
        else
        begin
            direction_reg      <= direction_next;
            escape_pending_reg <= escape_pending_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_escape_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
        escape_pending_reg |-> direction_reg == fbsc_pkg::DIR_DECODE)
        else $error("escape pending while encoding");
`endif

endmodule

>>> rtl/fbsc_queue.sv
// fbsc_queue: short register queue of commands between front and back
// uses fbsc_pkg
module fbsc_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fbsc_pkg::cmd_t push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output logic           head_valid,
    output fbsc_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbsc_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/fbsc_back.sv
// fbsc_back: walks the head command result by result into the output register
// uses fbsc_pkg and the result channel interface
module fbsc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  fbsc_pkg::cmd_t head_cmd,
    output logic           pop,
    fbsc_result_if.source  result
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       eof_reg;
    logic       last_reg;
    logic       sub_reg;
    logic       sub_next;
    logic       load;
    logic       take;
    logic [7:0] sel_byte;
    logic       sel_valid;
    logic       sel_eof;
    logic       sel_last;

    assign load = !out_valid_reg || result.ready;
    assign take = load && head_valid;

    always_comb
    begin
        if (sub_reg)
        begin
            sel_byte  = head_cmd.byte1;
            sel_valid = head_cmd.valid1;
            sel_eof   = head_cmd.eof1;
            sel_last  = 1'b1;
        end
        else
        begin
            sel_byte  = head_cmd.byte0;
            sel_valid = head_cmd.valid0;
            sel_eof   = head_cmd.eof0;
            sel_last  = !head_cmd.two;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sub_next       = sub_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
        end
        if (take)
        begin
            if (!sub_reg && head_cmd.two)
            begin
                sub_next = 1'b1;
            end
            else
            begin
                sub_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg   <= sel_byte;
            byte_valid_reg <= sel_valid;
            eof_reg        <= sel_eof;
            last_reg       <= sel_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_byte_reg;
    assign result.byte_valid   = byte_valid_reg;
    assign result.end_of_frame = eof_reg;
    assign result.last         = last_reg;

`ifndef NO_ASSERTIONS
    a_pair_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> head_valid && head_cmd.two)
        else $error("second result without its command");

    a_pair_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> out_valid_reg && !last_reg)
        else $error("second result pending without first on output");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && last_reg)
        else $error("command retired without final result");
`endif

endmodule

>>> rtl/frame_byte_stuffing_codec_core.sv
// frame_byte_stuffing_codec_core: top level of the byte-stuffing codec
// uses fbsc_pkg, fbsc channel interfaces, fbsc_front, fbsc_queue, fbsc_back
//
// Escapes (direction 0) or unescapes (direction 1) a frame byte stream. Each
// input transfer is classified at once into zero, one or two results and
// placed in a queue of QUEUE_DEPTH commands; the output register drains one
// result transfer per cycle unless result.ready holds it. A byte that gives
// two results (an escape pair, or a broken escape not followed by another
// escape) holds the single output register for both in turn, while the queue
// takes further bytes until it is full. The first result of a byte goes
// through the queue register and then the output register. The direction
// write also clears the decode escape state; write it only while idle.
module frame_byte_stuffing_codec_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    fbsc_cfg_if.sink      cfg,
    fbsc_item_if.sink     item,
    fbsc_result_if.source result
);

    logic           q_push;
    logic           q_ready;
    logic           q_pop;
    logic           q_head_valid;
    fbsc_pkg::cmd_t q_push_cmd;
    fbsc_pkg::cmd_t q_head_cmd;

    fbsc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd)
    );

    fbsc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    fbsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .result     (result)
    );

endmodule
